// ===== sv/charge_temperature_zone_fsm_assert.svh =====
// Assertion macros used by the charge temperature zone top level.
`ifndef CHARGE_TEMPERATURE_ZONE_FSM_ASSERT_SVH
`define CHARGE_TEMPERATURE_ZONE_FSM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTZ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ctz assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CTZ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ctz assertion failed");

`endif

// ===== sv/ctz_pkg.sv =====
// Types, constants and helper functions of the charge temperature zone block.
package ctz_pkg;

	localparam int TIME_WIDTH = 32;
	localparam int TEMP_W     = 13;
	localparam int HYST_W     = 12;
	localparam int IVAL_W     = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CMP_W      = 15;

	typedef logic [TIME_WIDTH-1:0] time_t;
	typedef logic signed [TEMP_W-1:0] temp_t;
	typedef logic signed [CMP_W-1:0] cmp_t;

	typedef enum logic [2:0] {
		Z_UNKNOWN = 3'd0,
		Z_NORMAL  = 3'd1,
		Z_OVER    = 3'd2,
		Z_UNDER   = 3'd3,
		Z_REDUCED = 3'd4
	} zone_t;

	typedef enum logic [1:0] {
		EV_NORMAL  = 2'd0,
		EV_OVER    = 2'd1,
		EV_UNDER   = 2'd2,
		EV_REDUCED = 2'd3
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HIGH_LIMIT     = 3'd0,
		REG_REDUCE_LIMIT   = 3'd1,
		REG_LOW_LIMIT      = 3'd2,
		REG_HYST           = 3'd3,
		REG_AWAKE_INTERVAL = 3'd4,
		REG_SLEEP_INTERVAL = 3'd5
	} cfg_idx_t;

	localparam temp_t            RST_HIGH_LIMIT     = 13'sd864;
	localparam temp_t            RST_REDUCE_LIMIT   = 13'sd640;
	localparam temp_t            RST_LOW_LIMIT      = 13'sd0;
	localparam logic [HYST_W-1:0] RST_HYST          = 12'd32;
	localparam logic [IVAL_W-1:0] RST_AWAKE_INTERVAL = 16'd1;
	localparam logic [IVAL_W-1:0] RST_SLEEP_INTERVAL = 16'd60;

	typedef struct packed {
		temp_t               high_limit;
		temp_t               reduce_limit;
		temp_t               low_limit;
		logic [HYST_W-1:0]   hyst;
		logic [IVAL_W-1:0]   awake_interval;
		logic [IVAL_W-1:0]   sleep_interval;
	} cfg_t;

	typedef struct packed {
		temp_t       temp_sample;
		logic [31:0] uptime_sec;
		logic        sleep_off;
		logic        woke;
	} item_t;

	typedef struct packed {
		logic   evaluate;
		logic   emit;
		zone_t  next_zone;
		event_t zone_event;
		time_t  next_last;
	} eval_res_t;

	function automatic event_t ev_of(zone_t z);
		event_t ev;
		unique case (z)
			Z_OVER:    ev = EV_OVER;
			Z_UNDER:   ev = EV_UNDER;
			Z_REDUCED: ev = EV_REDUCED;
			default:   ev = EV_NORMAL;
		endcase
		return ev;
	endfunction

endpackage

// ===== sv/ctz_if.sv =====
// Valid/ready channel interfaces for the sample input and the zone event output.
interface ctz_in_if;
	logic               valid;
	logic               ready;
	logic signed [12:0] temp_sample;
	logic [31:0]        uptime_sec;
	logic               sleep_off;
	logic               woke;

	modport source (output valid, output temp_sample, output uptime_sec,
		output sleep_off, output woke, input ready);
	modport sink (input valid, input temp_sample, input uptime_sec,
		input sleep_off, input woke, output ready);
endinterface

interface ctz_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] zone_event;

	modport source (output valid, output zone_event, input ready);
	modport sink (input valid, input zone_event, output ready);
endinterface

// ===== sv/ctz_cfg.sv =====
// Configuration register file with its write decoder.
module ctz_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ctz_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ctz_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output ctz_pkg::cfg_t                cfg
);
	import ctz_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_limit     <= RST_HIGH_LIMIT;
			cfg_q.reduce_limit   <= RST_REDUCE_LIMIT;
			cfg_q.low_limit      <= RST_LOW_LIMIT;
			cfg_q.hyst           <= RST_HYST;
			cfg_q.awake_interval <= RST_AWAKE_INTERVAL;
			cfg_q.sleep_interval <= RST_SLEEP_INTERVAL;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				REG_HIGH_LIMIT:     cfg_q.high_limit     <= cfg_wdata[TEMP_W-1:0];
				REG_REDUCE_LIMIT:   cfg_q.reduce_limit   <= cfg_wdata[TEMP_W-1:0];
				REG_LOW_LIMIT:      cfg_q.low_limit      <= cfg_wdata[TEMP_W-1:0];
				REG_HYST:           cfg_q.hyst           <= cfg_wdata[HYST_W-1:0];
				REG_AWAKE_INTERVAL: cfg_q.awake_interval <= cfg_wdata[IVAL_W-1:0];
				REG_SLEEP_INTERVAL: cfg_q.sleep_interval <= cfg_wdata[IVAL_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ===== sv/ctz_eval.sv =====
// Interval check and zone transition logic for one registered sample.
module ctz_eval (
	input  ctz_pkg::item_t     item,
	input  ctz_pkg::cfg_t      cfg,
	input  ctz_pkg::zone_t     zone,
	input  ctz_pkg::time_t     last_time,
	output ctz_pkg::eval_res_t res
);
	import ctz_pkg::*;

	time_t now;
	time_t last_eff;
	time_t interval;
	logic  evaluate;
	cmp_t  t;
	cmp_t  hi;
	cmp_t  rd;
	cmp_t  lo;
	cmp_t  hy;
	logic  is_high;
	logic  below_high_hyst;
	logic  is_red;
	logic  below_red_hyst;
	logic  is_low;
	logic  above_low_hyst;
	zone_t nxt;

	always_comb begin
		now      = time_t'(item.uptime_sec);
		last_eff = item.woke ? '0 : last_time;
		interval = time_t'(item.sleep_off ? cfg.awake_interval : cfg.sleep_interval);
		evaluate = (now - last_eff) >= interval;

		t  = cmp_t'(item.temp_sample);
		hi = cmp_t'(cfg.high_limit);
		rd = cmp_t'(cfg.reduce_limit);
		lo = cmp_t'(cfg.low_limit);
		hy = cmp_t'(cfg.hyst);

		is_high         = t >= hi;
		below_high_hyst = t <= hi - hy;
		is_red          = t >= rd;
		below_red_hyst  = t <= rd - hy;
		is_low          = t <= lo;
		above_low_hyst  = t >= lo + hy;

		nxt = zone;
		unique case (zone)
			Z_NORMAL: begin
				if (is_low) nxt = Z_UNDER;
				else if (is_high) nxt = Z_OVER;
				else if (is_red) nxt = Z_REDUCED;
			end
			Z_UNDER: begin
				if (is_high) nxt = Z_OVER;
				else if (is_red) nxt = Z_REDUCED;
				else if (above_low_hyst) nxt = Z_NORMAL;
			end
			Z_OVER: begin
				if (is_low) nxt = Z_UNDER;
				else if (below_high_hyst && is_red) nxt = Z_REDUCED;
				else if (below_red_hyst) nxt = Z_NORMAL;
			end
			Z_REDUCED: begin
				if (is_high) nxt = Z_OVER;
				else if (is_low) nxt = Z_UNDER;
				else if (below_red_hyst) nxt = Z_NORMAL;
			end
			default: begin
				if (is_low) nxt = Z_UNDER;
				else if (is_high) nxt = Z_OVER;
				else if (is_red) nxt = Z_REDUCED;
				else nxt = Z_NORMAL;
			end
		endcase

		res.evaluate   = evaluate;
		res.emit       = evaluate && (nxt != zone);
		res.next_zone  = evaluate ? nxt : zone;
		res.zone_event = ev_of(nxt);
		res.next_last  = evaluate ? now : last_eff;
	end
endmodule

// ===== sv/charge_temperature_zone_fsm.sv =====
// Top level of the charge temperature zone machine.
//
// Channel  Dir  Fields                                        Transfer when
// in_ch    in   temp_sample, uptime_sec, sleep_off, woke      valid && ready
// out_ch   out  zone_event                                    valid && ready
// cfg      in   cfg_idx, cfg_wdata                            cfg_we
//
// A sample is registered on transfer and evaluated in the following cycle. When it
// leaves the input register, the zone and last evaluation time update, and a change of
// zone loads the zone event into the output register at the same edge. One sample is
// taken per cycle unless a stalled output holds a sample that would produce an event.
// Reset clears the zone to unknown, the last evaluation time to zero and loads
// the register defaults. A stalled output blocks the input only when the sample
// waiting in the input register would produce an event.
module charge_temperature_zone_fsm (
	input  logic                           clk,
	input  logic                           arst_n,
	ctz_in_if.sink                         in_ch,
	ctz_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [ctz_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ctz_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import ctz_pkg::*;
	`include "charge_temperature_zone_fsm_assert.svh"

	cfg_t      cfg;
	item_t     item_s1;
	logic      valid_s1;
	zone_t     zone_q;
	time_t     last_q;
	eval_res_t res;
	logic      adv_s1;
	logic      in_xfer;
	logic      out_valid_q;
	event_t    zone_event_q;

	ctz_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ctz_eval u_eval (
		.item      (item_s1),
		.cfg       (cfg),
		.zone      (zone_q),
		.last_time (last_q),
		.res       (res)
	);

	assign adv_s1      = valid_s1 && (!res.emit || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv_s1;
	assign in_xfer     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.temp_sample <= in_ch.temp_sample;
			item_s1.uptime_sec  <= in_ch.uptime_sec;
			item_s1.sleep_off   <= in_ch.sleep_off;
			item_s1.woke        <= in_ch.woke;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= Z_UNKNOWN;
			last_q <= '0;
		end else if (adv_s1) begin
			zone_q <= res.next_zone;
			last_q <= res.next_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res.emit) begin
			zone_event_q <= res.zone_event;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.zone_event = zone_event_q;

	`CTZ_ASSERT_NEXT(a_zone_known, clk, arst_n, zone_q != Z_UNKNOWN, zone_q != Z_UNKNOWN)
	`CTZ_ASSERT_NEXT(a_event_matches_zone, clk, arst_n, adv_s1 && res.emit,
		out_valid_q && (zone_event_q == ev_of(zone_q)))
	`CTZ_ASSERT_NEXT(a_sample_held, clk, arst_n, valid_s1 && !adv_s1, valid_s1)
	`CTZ_ASSERT_NEXT(a_woke_clears, clk, arst_n,
		adv_s1 && item_s1.woke && !res.evaluate, last_q == '0)
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the charge temperature zone machine.
module tb_top;
	import ctz_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 130;
	localparam int TEMP_MIN    = -640;
	localparam int TEMP_MAX    = 2400;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	ctz_in_if  in_ch ();
	ctz_out_if out_ch ();

	charge_temperature_zone_fsm dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	cfg_t   cfg_shadow;
	zone_t  zone_shadow;
	time_t  last_eval_shadow;
	event_t zone_events_due[$];
	event_t due_event;
	int     error_count;
	int     quiet_cycles;
	bit     sender_gaps_on = 1'b1;
	bit     sink_stalls_on = 1'b1;
	bit     hold_request;
	int     hold_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else if (!sink_stalls_on) begin
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= 35);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (zone_events_due.size() == 0) begin
				$error("zone_event: expected none, actual %0d", out_ch.zone_event);
				error_count++;
			end else begin
				due_event = zone_events_due.pop_front();
				if (out_ch.zone_event !== due_event) begin
					$error("zone_event: expected %0d, actual %0d", due_event, out_ch.zone_event);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic void advance_zone_model(item_t s);
		int          t, hi, rd, lo, hy;
		logic [31:0] ival, elapsed;
		bit          hot, under_hot, warm, under_warm, cold, over_cold;
		zone_t       nxt;
		event_t      ev;
		t = int'($signed(s.temp_sample));
		hi = int'($signed(cfg_shadow.high_limit));
		rd = int'($signed(cfg_shadow.reduce_limit));
		lo = int'($signed(cfg_shadow.low_limit));
		hy = int'(cfg_shadow.hyst);
		if (s.woke)
			last_eval_shadow = '0;
		ival = s.sleep_off ? 32'(cfg_shadow.awake_interval) : 32'(cfg_shadow.sleep_interval);
		elapsed = s.uptime_sec - last_eval_shadow;
		if (elapsed < ival)
			return;
		last_eval_shadow = s.uptime_sec;
		hot = t >= hi;
		under_hot = t <= hi - hy;
		warm = t >= rd;
		under_warm = t <= rd - hy;
		cold = t <= lo;
		over_cold = t >= lo + hy;
		nxt = zone_shadow;
		case (zone_shadow)
			Z_NORMAL: begin
				if (cold) nxt = Z_UNDER;
				else if (hot) nxt = Z_OVER;
				else if (warm) nxt = Z_REDUCED;
			end
			Z_UNDER: begin
				if (hot) nxt = Z_OVER;
				else if (warm) nxt = Z_REDUCED;
				else if (over_cold) nxt = Z_NORMAL;
			end
			Z_OVER: begin
				if (cold) nxt = Z_UNDER;
				else if (under_hot && warm) nxt = Z_REDUCED;
				else if (under_warm) nxt = Z_NORMAL;
			end
			Z_REDUCED: begin
				if (hot) nxt = Z_OVER;
				else if (cold) nxt = Z_UNDER;
				else if (under_warm) nxt = Z_NORMAL;
			end
			default: begin
				if (cold) nxt = Z_UNDER;
				else if (hot) nxt = Z_OVER;
				else if (warm) nxt = Z_REDUCED;
				else nxt = Z_NORMAL;
			end
		endcase
		if (nxt == zone_shadow)
			return;
		zone_shadow = nxt;
		case (nxt)
			Z_OVER:    ev = EV_OVER;
			Z_UNDER:   ev = EV_UNDER;
			Z_REDUCED: ev = EV_REDUCED;
			default:   ev = EV_NORMAL;
		endcase
		zone_events_due.push_back(ev);
	endfunction

	function automatic item_t sample_of(int t, logic [31:0] up, bit awake, bit wk);
		item_t s;
		s.temp_sample = temp_t'(t);
		s.uptime_sec = up;
		s.sleep_off = awake;
		s.woke = wk;
		return s;
	endfunction

	function automatic int rand_temp();
		int t, hi, rd, lo, hy;
		hi = int'($signed(cfg_shadow.high_limit));
		rd = int'($signed(cfg_shadow.reduce_limit));
		lo = int'($signed(cfg_shadow.low_limit));
		hy = int'(cfg_shadow.hyst);
		if ($urandom_range(99) < 50) begin
			case ($urandom_range(5))
				0:       t = hi;
				1:       t = rd;
				2:       t = lo;
				3:       t = hi - hy;
				4:       t = rd - hy;
				default: t = lo + hy;
			endcase
			t = t + int'($urandom_range(4)) - 2;
		end else begin
			t = int'($urandom_range(TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
		end
		if (t < TEMP_MIN) t = TEMP_MIN;
		if (t > TEMP_MAX) t = TEMP_MAX;
		return t;
	endfunction

	function automatic logic [31:0] next_uptime(bit awake, bit wk);
		logic [31:0] base, ival;
		int          r;
		base = wk ? 32'd0 : last_eval_shadow;
		ival = awake ? 32'(cfg_shadow.awake_interval) : 32'(cfg_shadow.sleep_interval);
		r = $urandom_range(99);
		if (r < 50)
			return base + ival + $urandom_range(2);
		else if (r < 70)
			return base + ival - 1;
		else if (r < 85)
			return base + $urandom_range(ival);
		return $urandom;
	endfunction

	function automatic item_t random_sample();
		item_t s;
		s.woke = ($urandom_range(99) < 8);
		s.sleep_off = 1'($urandom_range(1));
		s.temp_sample = temp_t'(rand_temp());
		s.uptime_sec = next_uptime(s.sleep_off, s.woke);
		return s;
	endfunction

	function automatic logic [IVAL_W-1:0] random_interval();
		int r;
		r = $urandom_range(99);
		if (r < 60) return IVAL_W'($urandom_range(3));
		if (r < 80) return IVAL_W'($urandom_range(65535));
		if (r < 90) return 16'hFFFF;
		return '0;
	endfunction

	function automatic cfg_t random_config();
		cfg_t c;
		int   a, b, d, tmp;
		a = int'($urandom_range(TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
		b = int'($urandom_range(TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
		d = int'($urandom_range(TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
		if ($urandom_range(99) < 70) begin
			if (a > b) begin tmp = a; a = b; b = tmp; end
			if (b > d) begin tmp = b; b = d; d = tmp; end
			if (a > b) begin tmp = a; a = b; b = tmp; end
		end
		c.low_limit = temp_t'(a);
		c.reduce_limit = temp_t'(b);
		c.high_limit = temp_t'(d);
		c.hyst = ($urandom_range(99) < 70) ? HYST_W'($urandom_range(64))
			: HYST_W'($urandom_range(3040));
		c.awake_interval = random_interval();
		c.sleep_interval = random_interval();
		return c;
	endfunction

	task automatic send_sample(item_t s);
		int gap;
		gap = 0;
		if (sender_gaps_on)
			while (gap < 8 && $urandom_range(99) < 35)
				gap++;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.temp_sample <= s.temp_sample;
		in_ch.uptime_sec <= s.uptime_sec;
		in_ch.sleep_off <= s.sleep_off;
		in_ch.woke <= s.woke;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		advance_zone_model(s);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (zone_events_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	task automatic apply_config(cfg_t c);
		write_reg(REG_HIGH_LIMIT, 16'($signed(c.high_limit)));
		write_reg(REG_REDUCE_LIMIT, 16'($signed(c.reduce_limit)));
		write_reg(REG_LOW_LIMIT, 16'($signed(c.low_limit)));
		write_reg(REG_HYST, 16'(c.hyst));
		write_reg(REG_AWAKE_INTERVAL, c.awake_interval);
		write_reg(REG_SLEEP_INTERVAL, c.sleep_interval);
		cfg_we <= 1'b0;
		cfg_shadow = c;
	endtask

	task automatic test_directed_defaults();
		send_sample(sample_of(100, 32'd0, 1'b1, 1'b0));
		send_sample(sample_of(100, 32'd10, 1'b0, 1'b1));
		send_sample(sample_of(-640, 32'd100, 1'b1, 1'b0));
		send_sample(sample_of(2400, 32'd101, 1'b1, 1'b0));
		send_sample(sample_of(700, 32'd102, 1'b1, 1'b0));
		send_sample(sample_of(600, 32'd103, 1'b1, 1'b0));
		send_sample(sample_of(0, 32'd104, 1'b1, 1'b0));
		send_sample(sample_of(31, 32'd105, 1'b1, 1'b0));
		send_sample(sample_of(32, 32'd106, 1'b1, 1'b0));
		send_sample(sample_of(864, 32'd107, 1'b1, 1'b0));
		send_sample(sample_of(833, 32'd108, 1'b1, 1'b0));
		send_sample(sample_of(609, 32'd109, 1'b1, 1'b0));
		send_sample(sample_of(608, 32'd110, 1'b1, 1'b0));
		send_sample(sample_of(640, 32'd110, 1'b1, 1'b0));
		send_sample(sample_of(640, 32'd111, 1'b1, 1'b0));
		send_sample(sample_of(0, 32'd112, 1'b1, 1'b0));
		send_sample(sample_of(2400, 32'd142, 1'b0, 1'b0));
		send_sample(sample_of(2400, 32'd172, 1'b0, 1'b0));
		send_sample(sample_of(-640, 32'hFFFF_FFFF, 1'b1, 1'b0));
		send_sample(sample_of(2400, 32'd5, 1'b1, 1'b0));
		send_sample(sample_of(-640, 32'd6, 1'b1, 1'b1));
		send_sample(sample_of(863, 32'd7, 1'b1, 1'b0));
		send_sample(sample_of(864, 32'd8, 1'b1, 1'b0));
		send_sample(sample_of(610, 32'd9, 1'b1, 1'b0));
		send_sample(sample_of(-1, 32'd10, 1'b1, 1'b0));
		wait_drained();
	endtask

	task automatic test_register_extremes();
		cfg_t corners[4];
		corners[0] = '{high_limit: 13'sd2400, reduce_limit: 13'sd2400, low_limit: -13'sd640,
			hyst: 12'd3040, awake_interval: 16'd0, sleep_interval: 16'd0};
		corners[1] = '{high_limit: -13'sd640, reduce_limit: -13'sd640, low_limit: 13'sd2400,
			hyst: 12'd0, awake_interval: 16'hFFFF, sleep_interval: 16'hFFFF};
		corners[2] = '{high_limit: 13'sd2400, reduce_limit: -13'sd640, low_limit: -13'sd640,
			hyst: 12'd0, awake_interval: 16'd0, sleep_interval: 16'hFFFF};
		corners[3] = '{high_limit: -13'sd640, reduce_limit: 13'sd2400, low_limit: -13'sd640,
			hyst: 12'd3040, awake_interval: 16'hFFFF, sleep_interval: 16'd0};
		foreach (corners[k]) begin
			apply_config(corners[k]);
			repeat (15) send_sample(random_sample());
			wait_drained();
		end
	endtask

	task automatic test_random_traffic();
		for (int p = 0; p < 11; p++) begin
			sender_gaps_on = (p != 5);
			sink_stalls_on = (p != 5);
			apply_config(random_config());
			repeat (PHASE_ITEMS) send_sample(random_sample());
			wait_drained();
		end
		sender_gaps_on = 1'b1;
		sink_stalls_on = 1'b1;
	endtask

	task automatic test_output_backpressure();
		cfg_t c;
		c = '{high_limit: RST_HIGH_LIMIT, reduce_limit: RST_REDUCE_LIMIT, low_limit: RST_LOW_LIMIT,
			hyst: RST_HYST, awake_interval: 16'd0, sleep_interval: 16'd0};
		apply_config(c);
		sender_gaps_on = 1'b0;
		hold_request = 1'b1;
		for (int k = 0; k < 40; k++)
			send_sample(sample_of((k % 2) ? TEMP_MIN : TEMP_MAX, $urandom,
				1'($urandom_range(1)), 1'b0));
		wait_drained();
		sender_gaps_on = 1'b1;
	endtask

	task automatic test_sender_pause();
		apply_config(random_config());
		repeat (20) send_sample(random_sample());
		wait_drained();
		repeat (20) send_sample(random_sample());
		wait_drained();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_HIGH_LIMIT;
		cfg_wdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.temp_sample <= '0;
		in_ch.uptime_sec <= '0;
		in_ch.sleep_off <= 1'b0;
		in_ch.woke <= 1'b0;
		cfg_shadow = '{high_limit: RST_HIGH_LIMIT, reduce_limit: RST_REDUCE_LIMIT,
			low_limit: RST_LOW_LIMIT, hyst: RST_HYST,
			awake_interval: RST_AWAKE_INTERVAL, sleep_interval: RST_SLEEP_INTERVAL};
		zone_shadow = Z_UNKNOWN;
		last_eval_shadow = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_defaults();
		test_register_extremes();
		test_random_traffic();
		test_output_backpressure();
		test_sender_pause();
		repeat (10) @(posedge clk);
		if (error_count == 0 && zone_events_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
